// ===== hdl/mrs_pkg.sv =====
// shared types, constants and codes of the montgomery repeated squaring core
// no dependencies
`default_nettype none
package mrs_pkg;

  localparam int OPERAND_BITS = 2048;
  localparam int MAX_LIMBS    = 32;
  localparam int LIMBS        = (OPERAND_BITS / 64 > MAX_LIMBS) ? MAX_LIMBS : OPERAND_BITS / 64;
  localparam int LAW          = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int SCR_DEPTH    = 2 * LIMBS + 1;
  localparam int SAW          = $clog2(SCR_DEPTH);

  localparam logic [SAW-1:0] K_LIMBS    = SAW'(LIMBS);
  localparam logic [SAW-1:0] K_LAST_LOW = SAW'(LIMBS - 1);
  localparam logic [SAW-1:0] K_LAST_SQ  = SAW'(2 * LIMBS - 1);
  localparam logic [SAW-1:0] K_LAST_SCR = SAW'(2 * LIMBS);
  localparam logic [LAW-1:0] I_LAST     = LAW'(LIMBS - 1);

  typedef enum logic [1:0] {
    OP_LOAD_MOD = 2'd0,
    OP_LOAD_INV = 2'd1,
    OP_LOAD_VAL = 2'd2,
    OP_RUN      = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [4:0]  limb_index;
    logic [63:0] limb_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_limb;
    logic        last_limb;
  } out_item_t;

  // product pass: square, low product with inverse, add m times modulus
  typedef enum logic [1:0] {
    P_SQ = 2'd0,
    P_M  = 2'd1,
    P_U  = 2'd2
  } pass_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_ROW_RD,
    S_ROW_LD,
    S_STEP_RD,
    S_STEP_GO,
    S_STEP_WAIT,
    S_STEP_WR,
    S_TOP_RD,
    S_TOP_LD,
    S_SUB_RD,
    S_SUB_WR,
    S_CP_RD,
    S_CP_WR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [64:0] addend;
  } mac_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] acc;
  } mac_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/mrs_mac.sv =====
// shared multiply-accumulate unit: acc = a * b + addend, 64x64 bits
// one 32x32 partial product per cycle; uses mrs_pkg
`default_nettype none
module mrs_mac (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mrs_pkg::mac_req_t req,
  output mrs_pkg::mac_rsp_t      rsp
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    a_half = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    b_half = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp     = 64'(a_half) * 64'(b_half);
    case (cnt_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = {63'd0, req.addend};
      cnt_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp_sh;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
  end

  assign rsp.done = done_r;
  assign rsp.acc  = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("mac done without a running product");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != 2'd3 |=> busy_r) else $error("mac stopped early");
  a_four_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> ##3 done_nxt || req.start || $past(req.start, 1) == 1'b0)
    else $error("mac latency broken");

endmodule
`default_nettype wire

// ===== hdl/montgomery_repeated_squaring_core.sv =====
// montgomery repeated squaring core: stores, sequencer and result channel
// depends on mrs_pkg and mrs_mac
//
// usage: load items (operation 0, 1, 2) write one 64-bit limb of the modulus,
// the negated inverse or the start value, least significant limb at index 0;
// they are taken one a cycle while idle and give no result. a limb index at
// or beyond the operand length is dropped. a run item (operation 3) squares
// the value cfg-count times by montgomery reduction, writes it back and then
// sends the limbs out least significant first, last_limb set on the top limb.
// cfg_we writes the squaring count; write it only while the core is idle.
// during a run in_stall stays high. each squaring works the schoolbook
// products through the one mac unit, some 3.5 L^2 limb steps, each of which
// reads its operands, starts the mac, waits for done and writes the sum;
// on top come row loads and clear, subtract and copy sweeps of order L.
// results leave through an output register; a stalled beat holds until
// taken, and only then is the next limb read. reset clears the count, the
// sequencer and the output valid; the limb stores hold nothing until loaded.
`default_nettype none
module montgomery_repeated_squaring_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mrs_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mrs_pkg::out_item_t     out_item,
  input  wire logic              cfg_we,
  input  wire logic [63:0]       cfg_wdata
);

  localparam int LIMBS = mrs_pkg::LIMBS;
  localparam int LAW   = mrs_pkg::LAW;
  localparam int SAW   = mrs_pkg::SAW;

  mrs_pkg::state_t state_r, state_nxt;
  mrs_pkg::pass_t  pass_r;

  logic [63:0]    count_r;
  logic [63:0]    sq_left_r;
  logic [LAW-1:0] i_r;
  logic [SAW-1:0] k_r;
  logic [63:0]    a_r;
  logic [63:0]    carry_r;
  logic           borrow_r;
  logic           top_r;
  logic           out_valid_r;
  logic [63:0]    out_limb_r;
  logic           out_last_r;

  // limb stores
  logic [63:0] mod_mem [LIMBS];
  logic [63:0] inv_mem [LIMBS];
  logic [63:0] val_mem [LIMBS];
  logic [63:0] low_mem [LIMBS];
  logic [63:0] scr_mem [mrs_pkg::SCR_DEPTH];
  logic [63:0] mod_rd, inv_rd, val_rd, low_rd, scr_rd;

  logic [LAW-1:0] mod_ra, inv_ra, val_ra, low_ra, val_wa, low_wa;
  logic [SAW-1:0] scr_ra, scr_wa;
  logic           val_we, low_we, scr_we;
  logic [63:0]    val_wd, low_wd, scr_wd;

  logic           in_acc, load_ok;
  logic [SAW-1:0] j, k_last, k_hi;
  logic           j_ok, k_end, use_diff;
  logic [63:0]    b_sel, dst_sel, a_sel;
  logic [64:0]    diff;

  mrs_pkg::mac_req_t mac_req;
  mrs_pkg::mac_rsp_t mac_rsp;

  mrs_mac u_mac (
    .clk (clk),
    .rst_n (rst_n),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  assign in_stall = (state_r != mrs_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_ok  = ({1'b0, in_item.limb_index} < 6'(LIMBS));

  always_comb begin
    j      = k_r - SAW'(i_r);
    j_ok   = (j < mrs_pkg::K_LIMBS);
    k_hi   = mrs_pkg::K_LIMBS + k_r;
    unique case (pass_r)
      // the clear before a square also empties the carry limb on top
      mrs_pkg::P_SQ: k_last = (state_r == mrs_pkg::S_CLR) ? mrs_pkg::K_LAST_SCR
                                                           : mrs_pkg::K_LAST_SQ;
      mrs_pkg::P_M:  k_last = mrs_pkg::K_LAST_LOW;
      default:       k_last = mrs_pkg::K_LAST_SCR;
    endcase
    k_end  = (k_r == k_last);
    unique case (pass_r)
      mrs_pkg::P_SQ: begin
        a_sel = val_rd; b_sel = val_rd; dst_sel = scr_rd;
      end
      mrs_pkg::P_M: begin
        a_sel = scr_rd; b_sel = inv_rd; dst_sel = low_rd;
      end
      default: begin
        a_sel = low_rd; b_sel = mod_rd; dst_sel = scr_rd;
      end
    endcase
    diff     = {1'b0, scr_rd} - {1'b0, mod_rd} - 65'(borrow_r);
    use_diff = top_r || !borrow_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrs_pkg::S_IDLE:
        if (in_acc && in_item.operation == mrs_pkg::OP_RUN) begin
          state_nxt = (count_r == 64'd0) ? mrs_pkg::S_OUT_RD : mrs_pkg::S_CLR;
        end
      mrs_pkg::S_CLR:       if (k_end) state_nxt = mrs_pkg::S_ROW_RD;
      mrs_pkg::S_ROW_RD:    state_nxt = mrs_pkg::S_ROW_LD;
      mrs_pkg::S_ROW_LD:    state_nxt = mrs_pkg::S_STEP_RD;
      mrs_pkg::S_STEP_RD:   state_nxt = mrs_pkg::S_STEP_GO;
      mrs_pkg::S_STEP_GO:   state_nxt = mrs_pkg::S_STEP_WAIT;
      mrs_pkg::S_STEP_WAIT: if (mac_rsp.done) state_nxt = mrs_pkg::S_STEP_WR;
      mrs_pkg::S_STEP_WR:
        if (!k_end) begin
          state_nxt = mrs_pkg::S_STEP_RD;
        end else if (i_r != mrs_pkg::I_LAST) begin
          state_nxt = mrs_pkg::S_ROW_RD;
        end else begin
          unique case (pass_r)
            mrs_pkg::P_SQ: state_nxt = mrs_pkg::S_CLR;
            mrs_pkg::P_M:  state_nxt = mrs_pkg::S_ROW_RD;
            default:       state_nxt = mrs_pkg::S_TOP_RD;
          endcase
        end
      mrs_pkg::S_TOP_RD:    state_nxt = mrs_pkg::S_TOP_LD;
      mrs_pkg::S_TOP_LD:    state_nxt = mrs_pkg::S_SUB_RD;
      mrs_pkg::S_SUB_RD:    state_nxt = mrs_pkg::S_SUB_WR;
      mrs_pkg::S_SUB_WR:
        state_nxt = (k_r == mrs_pkg::K_LAST_LOW) ? mrs_pkg::S_CP_RD : mrs_pkg::S_SUB_RD;
      mrs_pkg::S_CP_RD:     state_nxt = mrs_pkg::S_CP_WR;
      mrs_pkg::S_CP_WR:
        if (k_r != mrs_pkg::K_LAST_LOW) begin
          state_nxt = mrs_pkg::S_CP_RD;
        end else begin
          state_nxt = (sq_left_r == 64'd1) ? mrs_pkg::S_OUT_RD : mrs_pkg::S_CLR;
        end
      mrs_pkg::S_OUT_RD:    state_nxt = mrs_pkg::S_OUT_LD;
      mrs_pkg::S_OUT_LD:    state_nxt = mrs_pkg::S_OUT_WAIT;
      mrs_pkg::S_OUT_WAIT:
        if (!out_stall) begin
          state_nxt = out_last_r ? mrs_pkg::S_IDLE : mrs_pkg::S_OUT_RD;
        end
      default:              state_nxt = mrs_pkg::S_IDLE;
    endcase
  end

  // memory ports and mac request
  always_comb begin
    val_ra = j[LAW-1:0];
    mod_ra = j[LAW-1:0];
    inv_ra = j[LAW-1:0];
    low_ra = k_r[LAW-1:0];
    scr_ra = k_r;
    val_we = 1'b0;
    val_wa = in_item.limb_index[LAW-1:0];
    val_wd = in_item.limb_value;
    low_we = 1'b0;
    low_wa = k_r[LAW-1:0];
    low_wd = 64'd0;
    scr_we = 1'b0;
    scr_wa = k_r;
    scr_wd = 64'd0;
    mac_req.start  = 1'b0;
    mac_req.a      = a_r;
    mac_req.b      = j_ok ? b_sel : 64'd0;
    mac_req.addend = {1'b0, dst_sel} + {1'b0, carry_r};
    unique case (state_r)
      mrs_pkg::S_IDLE:
        val_we = in_acc && load_ok && in_item.operation == mrs_pkg::OP_LOAD_VAL;
      mrs_pkg::S_CLR: begin
        scr_we = (pass_r == mrs_pkg::P_SQ);
        low_we = (pass_r == mrs_pkg::P_M);
      end
      mrs_pkg::S_ROW_RD: begin
        val_ra = i_r;
        scr_ra = SAW'(i_r);
        low_ra = i_r;
      end
      mrs_pkg::S_STEP_GO: mac_req.start = 1'b1;
      mrs_pkg::S_STEP_WR: begin
        scr_we = (pass_r != mrs_pkg::P_M);
        low_we = (pass_r == mrs_pkg::P_M);
        scr_wd = mac_rsp.acc[63:0];
        low_wd = mac_rsp.acc[63:0];
      end
      mrs_pkg::S_TOP_RD: scr_ra = mrs_pkg::K_LAST_SCR;
      mrs_pkg::S_SUB_RD: begin
        scr_ra = k_hi;
        mod_ra = k_r[LAW-1:0];
      end
      mrs_pkg::S_SUB_WR: begin
        low_we = 1'b1;
        low_wd = diff[63:0];
      end
      mrs_pkg::S_CP_RD: scr_ra = k_hi;
      mrs_pkg::S_CP_WR: begin
        val_we = 1'b1;
        val_wa = k_r[LAW-1:0];
        val_wd = use_diff ? low_rd : scr_rd;
      end
      mrs_pkg::S_OUT_RD: val_ra = k_r[LAW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && load_ok && in_item.operation == mrs_pkg::OP_LOAD_MOD) begin
      mod_mem[in_item.limb_index[LAW-1:0]] <= in_item.limb_value;
    end
    if (in_acc && load_ok && in_item.operation == mrs_pkg::OP_LOAD_INV) begin
      inv_mem[in_item.limb_index[LAW-1:0]] <= in_item.limb_value;
    end
    if (val_we) val_mem[val_wa] <= val_wd;
    if (low_we) low_mem[low_wa] <= low_wd;
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    mod_rd <= mod_mem[mod_ra];
    inv_rd <= inv_mem[inv_ra];
    val_rd <= val_mem[val_ra];
    low_rd <= low_mem[low_ra];
    scr_rd <= scr_mem[scr_ra];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrs_pkg::S_IDLE;
      pass_r      <= mrs_pkg::P_SQ;
      count_r     <= 64'd0;
      sq_left_r   <= 64'd0;
      i_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) count_r <= cfg_wdata;
      unique case (state_r)
        mrs_pkg::S_IDLE: begin
          sq_left_r <= count_r;
          pass_r    <= mrs_pkg::P_SQ;
          k_r       <= '0;
        end
        mrs_pkg::S_CLR: begin
          i_r <= '0;
          k_r <= k_end ? '0 : k_r + SAW'(1);
        end
        mrs_pkg::S_STEP_WR:
          if (!k_end) begin
            k_r <= k_r + SAW'(1);
          end else if (i_r != mrs_pkg::I_LAST) begin
            // row i starts at column i
            i_r <= i_r + LAW'(1);
            k_r <= SAW'(i_r) + SAW'(1);
          end else begin
            i_r <= '0;
            k_r <= '0;
            unique case (pass_r)
              mrs_pkg::P_SQ: pass_r <= mrs_pkg::P_M;
              mrs_pkg::P_M:  pass_r <= mrs_pkg::P_U;
              default:       pass_r <= mrs_pkg::P_U;
            endcase
          end
        mrs_pkg::S_TOP_LD: k_r <= '0;
        mrs_pkg::S_SUB_WR:
          k_r <= (k_r == mrs_pkg::K_LAST_LOW) ? '0 : k_r + SAW'(1);
        mrs_pkg::S_CP_WR:
          if (k_r != mrs_pkg::K_LAST_LOW) begin
            k_r <= k_r + SAW'(1);
          end else begin
            k_r       <= '0;
            pass_r    <= mrs_pkg::P_SQ;
            sq_left_r <= sq_left_r - 64'd1;
          end
        mrs_pkg::S_OUT_LD: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (k_r == mrs_pkg::K_LAST_LOW);
        end
        mrs_pkg::S_OUT_WAIT:
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + SAW'(1);
          end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == mrs_pkg::S_ROW_LD) a_r <= a_sel;
  end

  always_ff @(posedge clk) begin
    if (state_r == mrs_pkg::S_ROW_LD) carry_r <= 64'd0;
    else if (state_r == mrs_pkg::S_STEP_WR) carry_r <= mac_rsp.acc[127:64];
    if (state_r == mrs_pkg::S_TOP_LD) begin
      top_r    <= (scr_rd != 64'd0);
      borrow_r <= 1'b0;
    end else if (state_r == mrs_pkg::S_SUB_WR) begin
      borrow_r <= diff[64];
    end
    if (state_r == mrs_pkg::S_OUT_LD) out_limb_r <= val_rd;
  end

  assign out_valid            = out_valid_r;
  assign out_item.result_limb = out_limb_r;
  assign out_item.last_limb   = out_last_r;

  a_out_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == mrs_pkg::S_OUT_WAIT) else $error("beat outside output wait");
  a_mac_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mac_rsp.done |-> state_r == mrs_pkg::S_STEP_WAIT) else $error("stray mac result");
  a_zero_count_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.operation == mrs_pkg::OP_RUN && count_r == 64'd0
    |=> state_r == mrs_pkg::S_OUT_RD) else $error("zero count run did not emit");
  a_squarings_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mrs_pkg::S_CLR && pass_r == mrs_pkg::P_SQ |-> sq_left_r != 64'd0)
    else $error("squaring started with none left");

endmodule
`default_nettype wire

// ===== tb/montgomery_repeated_squaring_core_test.sv =====
// self-checking bench for the montgomery repeated squaring core: loads limbs,
// runs squarings under several counts and checks every result beat in order
// depends on mrs_pkg and montgomery_repeated_squaring_core
`timescale 1ns / 1ps
module montgomery_repeated_squaring_core_test;

  localparam int WB        = 64 * mrs_pkg::LIMBS;
  localparam int MAX_CYC   = 3000000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mrs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mrs_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  mrs_pkg::in_item_t pending_items[$];
  mrs_pkg::out_item_t limb_queue[$];
  logic [63:0] mod_limbs[mrs_pkg::LIMBS];
  logic [63:0] inv_limbs[mrs_pkg::LIMBS];
  logic [63:0] val_limbs[mrs_pkg::LIMBS];
  logic [63:0] count_shadow = '0;
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  bit in_taken = 1'b0;

  montgomery_repeated_squaring_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // one redc squaring, carry out of the addition kept
  function automatic logic [WB-1:0] redc_square(logic [WB-1:0] x, logic [WB-1:0] n,
                                                 logic [WB-1:0] ni);
    logic [2*WB-1:0] t;
    logic [WB-1:0] m;
    logic [2*WB:0] u;
    logic [WB:0] h;
    t = {{WB{1'b0}}, x} * {{WB{1'b0}}, x};
    m = t[WB-1:0] * ni;
    u = {1'b0, t} + ({{(WB+1){1'b0}}, m} * {{(WB+1){1'b0}}, n});
    h = u[2*WB:WB];
    if (h[WB] || h[WB-1:0] >= n) return h[WB-1:0] - n;
    return h[WB-1:0];
  endfunction

  task automatic predict_beat(mrs_pkg::in_item_t it);
    logic [WB-1:0] x, n, ni;
    logic [63:0] left;
    mrs_pkg::out_item_t o;
    case (it.operation)
      mrs_pkg::OP_LOAD_MOD: mod_limbs[it.limb_index] = it.limb_value;
      mrs_pkg::OP_LOAD_INV: inv_limbs[it.limb_index] = it.limb_value;
      mrs_pkg::OP_LOAD_VAL: val_limbs[it.limb_index] = it.limb_value;
      default: begin
        for (int k = 0; k < mrs_pkg::LIMBS; k++) begin
          x[64*k +: 64] = val_limbs[k];
          n[64*k +: 64] = mod_limbs[k];
          ni[64*k +: 64] = inv_limbs[k];
        end
        left = count_shadow;
        while (left != 0) begin
          x = redc_square(x, n, ni);
          left--;
        end
        for (int k = 0; k < mrs_pkg::LIMBS; k++) begin
          val_limbs[k] = x[64*k +: 64];
          o.result_limb = x[64*k +: 64];
          o.last_limb = (k == mrs_pkg::LIMBS - 1);
          limb_queue.push_back(o);
        end
      end
    endcase
  endtask

  // input side: monitor at the rising edge, driver at the falling edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) predict_beat(in_item);
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk) begin
    mrs_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (limb_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h last %b", $realtime,
                 out_item.result_limb, out_item.last_limb);
      end else begin
        want = limb_queue.pop_front();
        if (out_item.result_limb !== want.result_limb) begin
          errors++;
          $display("%0t: result_limb expected %h got %h", $realtime,
                   want.result_limb, out_item.result_limb);
        end
        if (out_item.last_limb !== want.last_limb) begin
          errors++;
          $display("%0t: last_limb expected %b got %b", $realtime,
                   want.last_limb, out_item.last_limb);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYC) begin
      $display("montgomery_repeated_squaring_core_test: done, errors");
      $finish;
    end
  end

  function automatic mrs_pkg::in_item_t mk(mrs_pkg::op_t op, int idx, logic [63:0] v);
    mrs_pkg::in_item_t it;
    it.operation = op;
    it.limb_index = 5'(idx);
    it.limb_value = v;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic drain();
    while (!(pending_items.size() == 0 && !in_valid && limb_queue.size() == 0))
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(logic [63:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    count_shadow = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random loads of random stores, runs now and then
  task automatic random_burst(int n_items, int max_runs);
    int runs;
    runs = 0;
    for (int i = 0; i < n_items; i++) begin
      if (runs < max_runs && $urandom_range(99) < 12) begin
        pending_items.push_back(mk(mrs_pkg::OP_RUN, $urandom_range(31), rand64()));
        runs++;
      end else begin
        pending_items.push_back(mk(mrs_pkg::op_t'($urandom_range(2)), $urandom_range(31),
                                   rand64()));
      end
    end
    pending_items.push_back(mk(mrs_pkg::OP_RUN, 0, '0));
  endtask

  initial begin
    logic [WB-1:0] n, xi;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all-ones count only written, never run, then a real count
    set_count('1);
    set_count(64'd0);

    // well-formed setup: odd modulus, true negated inverse, start below modulus
    for (int k = 0; k < mrs_pkg::LIMBS; k++) n[64*k +: 64] = rand64();
    n[0] = 1'b1;
    n[WB-1] = 1'b1;
    xi = 1;
    for (int i = 0; i < 12; i++) xi = xi * (2 - n * xi);
    xi = -xi;
    calm = 1'b1;
    for (int k = 0; k < mrs_pkg::LIMBS; k++) begin
      pending_items.push_back(mk(mrs_pkg::OP_LOAD_MOD, k, n[64*k +: 64]));
      pending_items.push_back(mk(mrs_pkg::OP_LOAD_INV, k, xi[64*k +: 64]));
      pending_items.push_back(mk(mrs_pkg::OP_LOAD_VAL, k,
                                 (k == mrs_pkg::LIMBS - 1) ? 64'd0 : rand64()));
    end
    // zero count: value comes back unchanged
    pending_items.push_back(mk(mrs_pkg::OP_RUN, 31, '1));
    drain();
    calm = 1'b0;

    set_count(64'd1);
    pending_items.push_back(mk(mrs_pkg::OP_RUN, 0, '0));
    // result in place: second run continues from the first
    pending_items.push_back(mk(mrs_pkg::OP_RUN, 0, '0));
    drain();

    set_count(64'd2);
    pending_items.push_back(mk(mrs_pkg::OP_RUN, 0, '0));
    drain();

    // top limb all ones: value near r, carry out of the addition likely
    set_count(64'd1);
    pending_items.push_back(mk(mrs_pkg::OP_LOAD_VAL, mrs_pkg::LIMBS - 1, '1));
    pending_items.push_back(mk(mrs_pkg::OP_RUN, 0, '0));
    drain();

    // zero count with a long receiver hold while loads keep coming
    set_count(64'd0);
    hold_arm = 1'b1;
    pending_items.push_back(mk(mrs_pkg::OP_RUN, 0, '0));
    random_burst(12, 2);
    drain();

    // random limbs break the inverse and may leave the modulus even
    set_count(64'd1);
    random_burst(8, 1);
    drain();

    if (errors == 0) begin
      $display("montgomery_repeated_squaring_core_test: done, clean");
    end else begin
      $display("montgomery_repeated_squaring_core_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mrs_pkg.sv
hdl/mrs_mac.sv
hdl/montgomery_repeated_squaring_core.sv
tb/montgomery_repeated_squaring_core_test.sv
